FILE: src/region_spectrum_accumulator_assert.svh
// assertion macros for the checker file
`ifndef REGION_SPECTRUM_ACCUMULATOR_ASSERT_SVH
`define REGION_SPECTRUM_ACCUMULATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RSA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/rsa_pkg.sv
package rsa_pkg;

	// operation codes
	localparam logic [1:0] OP_WORD  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_A_X = 2'd0;
	localparam logic [1:0] CFG_A_Y = 2'd1;
	localparam logic [1:0] CFG_B_X = 2'd2;
	localparam logic [1:0] CFG_B_Y = 2'd3;

	// stream markers
	localparam logic signed [31:0] WORD_REC_END    = -32'sd1;
	localparam logic signed [31:0] WORD_STREAM_END = -32'sd2;

	// corners are whole millimetres, stream positions are micrometres
	localparam logic signed [32:0] MM_SCALE = 33'sd1000;

	// largest readout value
	localparam logic [31:0] OUT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] stream_word;
		logic [13:0]        read_channel;
	} rsa_in_t;

	typedef struct packed {
		logic [31:0] bin_value;
		logic        stream_done;
	} rsa_out_t;

	// bin update request from the parser
	typedef struct packed {
		logic               upd;
		logic               point;
		logic signed [31:0] count;
		logic signed [31:0] channel;
	} rsa_bin_req_t;

endpackage

FILE: src/rsa_ram.sv
module rsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/rsa_parser.sv
module rsa_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [1:0]            cfg_index,
	input  logic [21:0]           cfg_data,
	input  logic                  step,
	input  logic                  restart,
	input  logic signed [31:0]    word,
	output rsa_pkg::rsa_bin_req_t req,
	output logic                  done_next
);

	localparam logic [2:0] PH_X        = 3'd0;
	localparam logic [2:0] PH_Y        = 3'd1;
	localparam logic [2:0] PH_INTEGRAL = 3'd2;
	localparam logic [2:0] PH_COUNT    = 3'd3;
	localparam logic [2:0] PH_CHANNEL  = 3'd4;
	localparam logic [2:0] PH_SKIP     = 3'd5;
	localparam logic [2:0] PH_DONE     = 3'd6;

	logic [21:0]        cax_q, cay_q, cbx_q, cby_q;
	logic signed [32:0] ax_mm_q, ay_mm_q, bx_mm_q, by_mm_q;
	logic signed [32:0] mm_wr;
	logic [2:0]         phase_q, phase_nx;
	logic signed [31:0] held_x_q, held_x_nx;
	logic signed [31:0] held_count_q, held_count_nx;
	logic               done_q;
	logic               point;
	logic signed [32:0] x_w, y_w, lox, hix, loy, hiy;
	logic               sel;

	// corner scaled to micrometres when written
	assign mm_wr = 33'($signed(cfg_data)) * rsa_pkg::MM_SCALE;

	// corner registers, raw and scaled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cax_q   <= '0;
			cay_q   <= '0;
			cbx_q   <= '0;
			cby_q   <= '0;
			ax_mm_q <= '0;
			ay_mm_q <= '0;
			bx_mm_q <= '0;
			by_mm_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				rsa_pkg::CFG_A_X: begin
					cax_q   <= cfg_data;
					ax_mm_q <= mm_wr;
				end
				rsa_pkg::CFG_A_Y: begin
					cay_q   <= cfg_data;
					ay_mm_q <= mm_wr;
				end
				rsa_pkg::CFG_B_X: begin
					cbx_q   <= cfg_data;
					bx_mm_q <= mm_wr;
				end
				rsa_pkg::CFG_B_Y: begin
					cby_q   <= cfg_data;
					by_mm_q <= mm_wr;
				end
				default: begin
				end
			endcase
		end
	end

	// point mode when both corners coincide
	assign point = (cax_q == cbx_q) && (cay_q == cby_q);

	// rectangle bounds and record selection
	assign x_w = 33'(held_x_q);
	assign y_w = 33'(word);
	assign lox = (ax_mm_q < bx_mm_q) ? ax_mm_q : bx_mm_q;
	assign hix = (ax_mm_q < bx_mm_q) ? bx_mm_q : ax_mm_q;
	assign loy = (ay_mm_q < by_mm_q) ? ay_mm_q : by_mm_q;
	assign hiy = (ay_mm_q < by_mm_q) ? by_mm_q : ay_mm_q;
	assign sel = point ? ((x_w == ax_mm_q) && (y_w == ay_mm_q))
	                   : ((x_w >= lox) && (x_w <= hix) && (y_w >= loy) && (y_w <= hiy));

	// record parser
	always_comb begin
		phase_nx      = phase_q;
		held_x_nx     = held_x_q;
		held_count_nx = held_count_q;
		done_next     = done_q;
		req.upd       = 1'b0;
		req.point     = point;
		req.count     = held_count_q;
		req.channel   = word;
		if (restart) begin
			phase_nx      = PH_X;
			held_x_nx     = '0;
			held_count_nx = '0;
			done_next     = 1'b0;
		end else if (step && !done_q) begin
			unique case (phase_q)
				PH_X: begin
					if (word == rsa_pkg::WORD_STREAM_END) begin
						phase_nx  = PH_DONE;
						done_next = 1'b1;
					end else begin
						held_x_nx = word;
						phase_nx  = PH_Y;
					end
				end
				PH_Y: begin
					if (sel) begin
						phase_nx = PH_INTEGRAL;
					end else if (word == rsa_pkg::WORD_REC_END) begin
						phase_nx = PH_X;
					end else begin
						phase_nx = PH_SKIP;
					end
				end
				PH_INTEGRAL: begin
					phase_nx = PH_COUNT;
				end
				PH_COUNT: begin
					if (word == rsa_pkg::WORD_STREAM_END) begin
						phase_nx  = PH_DONE;
						done_next = 1'b1;
					end else if (word == rsa_pkg::WORD_REC_END) begin
						if (point) begin
							phase_nx  = PH_DONE;
							done_next = 1'b1;
						end else begin
							phase_nx = PH_X;
						end
					end else begin
						held_count_nx = word;
						phase_nx      = PH_CHANNEL;
					end
				end
				PH_CHANNEL: begin
					req.upd  = 1'b1;
					phase_nx = PH_COUNT;
				end
				PH_SKIP: begin
					if (word == rsa_pkg::WORD_STREAM_END) begin
						phase_nx  = PH_DONE;
						done_next = 1'b1;
					end else if (word == rsa_pkg::WORD_REC_END) begin
						phase_nx = PH_X;
					end
				end
				default: begin
					phase_nx  = PH_DONE;
					done_next = 1'b1;
				end
			endcase
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_X;
			held_x_q     <= '0;
			held_count_q <= '0;
			done_q       <= 1'b0;
		end else begin
			phase_q      <= phase_nx;
			held_x_q     <= held_x_nx;
			held_count_q <= held_count_nx;
			done_q       <= done_next;
		end
	end

endmodule

FILE: src/region_spectrum_accumulator.sv
// an accepted item passes the stage 1 registers, then its result is held in the output register
// no new item is taken while one is in stage 1, for the histogram read-modify-write
//   (registered read of the bin memory, one access in flight)
// a clear item restarts the parser and zeroes the bins one per cycle, taking no items
// reset: async active low; parser restarts, corners go to zero and the same
//   clearing pass runs before the first item is accepted
module region_spectrum_accumulator #(
	parameter int CHANNELS  = 16384,
	parameter int BIN_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_index,
	input  logic [21:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  rsa_pkg::rsa_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rsa_pkg::rsa_out_t out_data
);

	localparam int AW = $clog2(CHANNELS);
	localparam int OW = (BIN_WIDTH > 32) ? BIN_WIDTH : 32;
	localparam int SW = OW + 2;
	localparam logic [BIN_WIDTH-1:0] BIN_MAX = '1;

	rsa_pkg::rsa_bin_req_t req;
	rsa_pkg::rsa_out_t     out_q;
	logic                  accept, step, restart, done_next;
	logic [31:0]           ch32, rc32;
	logic                  wr_ok, rd_ok;
	logic [AW-1:0]         rd_addr;
	logic                  valid_s1, read_s1, rd_ok_s1, upd_s1, point_s1, done_s1;
	logic signed [31:0]    count_s1;
	logic [AW-1:0]         addr_s1;
	logic [BIN_WIDTH-1:0]  rd_data, bin_new, ram_wdata;
	logic signed [SW-1:0]  base_ext, cnt_ext, sum_ext, max_ext;
	logic [OW-1:0]         rd_wide;
	logic [31:0]           rd_sat;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic                  clearing_q;
	logic [AW-1:0]         clr_cnt_q;
	logic                  out_valid_q;

	// one item in flight, output slot must be free
	assign in_ready = !valid_s1 && !clearing_q && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign step     = accept && (in_data.operation == rsa_pkg::OP_WORD);
	assign restart  = accept && (in_data.operation == rsa_pkg::OP_CLEAR);

	rsa_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step),
		.restart   (restart),
		.word      (in_data.stream_word),
		.req       (req),
		.done_next (done_next)
	);

	// bin index range checks
	assign ch32    = $unsigned(req.channel);
	assign rc32    = 32'(in_data.read_channel);
	assign wr_ok   = !ch32[31] && (ch32 < 32'(CHANNELS));
	assign rd_ok   = rc32 < 32'(CHANNELS);
	assign rd_addr = (in_data.operation == rsa_pkg::OP_READ) ? rc32[AW-1:0] : ch32[AW-1:0];

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			read_s1  <= in_data.operation == rsa_pkg::OP_READ;
			rd_ok_s1 <= rd_ok;
			upd_s1   <= req.upd && wr_ok;
			point_s1 <= req.point;
			count_s1 <= req.count;
			addr_s1  <= rd_addr;
			done_s1  <= done_next;
		end
	end

	// saturating bin update, point mode assigns the clamped count
	always_comb begin
		base_ext = point_s1 ? '0 : $signed(SW'(rd_data));
		cnt_ext  = SW'(count_s1);
		sum_ext  = base_ext + cnt_ext;
		max_ext  = $signed(SW'(BIN_MAX));
		if (sum_ext[SW-1]) begin
			bin_new = '0;
		end else if (sum_ext > max_ext) begin
			bin_new = BIN_MAX;
		end else begin
			bin_new = sum_ext[BIN_WIDTH-1:0];
		end
	end

	// readout clamp to 32 bits
	assign rd_wide = OW'(rd_data);
	assign rd_sat  = (rd_wide > OW'(rsa_pkg::OUT_MAX)) ? rsa_pkg::OUT_MAX : rd_wide[31:0];

	// write port shared by the clearing pass and the update
	assign ram_we    = clearing_q || (valid_s1 && upd_s1);
	assign ram_waddr = clearing_q ? clr_cnt_q : addr_s1;
	assign ram_wdata = clearing_q ? '0 : bin_new;

	rsa_ram #(
		.WIDTH (BIN_WIDTH),
		.DEPTH (CHANNELS)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// clearing pass after reset and on a clear item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (restart) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			if (clr_cnt_q == AW'(CHANNELS - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			out_q.bin_value   <= (read_s1 && rd_ok_s1) ? rd_sat : '0;
			out_q.stream_done <= done_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: src/rsa_checker.sv
`include "region_spectrum_accumulator_assert.svh"

module rsa_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input rsa_pkg::rsa_in_t  in_data,
	input logic              out_valid,
	input logic              out_ready,
	input rsa_pkg::rsa_out_t out_data
);

	logic acc;
	logic acc_clear;

	assign acc       = in_valid && in_ready;
	assign acc_clear = acc && (in_data.operation == rsa_pkg::OP_CLEAR);

	// one item at a time
	`RSA_ASSERT_NEXT(a_one_in_flight, acc, !in_ready, "item accepted while another in flight")

	// every item yields a result once it has passed stage 1 and the output register
	`RSA_ASSERT_NOW(a_result_lat, acc, ##2 out_valid, "result missing two cycles after item")

	// clear result is empty and not done, and the sweep blocks input
	`RSA_ASSERT_NOW(a_clear_result, acc_clear,
		##2 (out_data.bin_value == 32'd0 && !out_data.stream_done), "bad clear result")
	`RSA_ASSERT_NEXT(a_clear_blocks, acc_clear, ##1 !in_ready, "input open during clear")

	// stalled result holds
	`RSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data),
		"stalled result changed")

endmodule

bind region_spectrum_accumulator rsa_checker u_rsa_checker (.*);

FILE: sim/tb_region_spectrum_accumulator.sv
module tb_region_spectrum_accumulator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_BINS = 16384;
	localparam int EPISODES = 14;
	localparam int EPISODE_ITEMS = 38;
	localparam longint BIN_TOP = 64'h0000_0000_FFFF_FFFF;

	// operation code with no function
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef enum logic [2:0] {
		AWAIT_X,
		AWAIT_Y,
		AWAIT_INTEGRAL,
		AWAIT_COUNT,
		AWAIT_CHANNEL,
		SKIP_REC,
		HALTED
	} rec_phase_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		rsa_pkg::rsa_in_t  item;
		bit                typed;
		rsa_pkg::rsa_out_t want;
		logic [1:0]        reg_idx;
		logic [21:0]       reg_val;
	} row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cfg_wr_en = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [21:0] cfg_data = '0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	rsa_pkg::rsa_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	rsa_pkg::rsa_out_t out_data;

	// predicted block state
	logic [31:0]        spectrum [NUM_BINS];
	rec_phase_t         rec_phase;
	logic signed [31:0] rec_x;
	logic signed [31:0] pend_count;
	bit                 stream_ended;
	logic [21:0]        corner [4];

	rsa_pkg::rsa_out_t expected_results [$];
	rsa_pkg::rsa_in_t  plan [$];
	row_t              rows [$];

	// driver to monitor: hand-typed result for the item on the bus
	bit                drv_typed = 1'b0;
	rsa_pkg::rsa_out_t drv_want = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fault_cnt = 0;
	int items_taken = 0;
	int results_checked = 0;
	int clears_taken = 0;
	int reads_taken = 0;
	int settings_cnt = 0;

	region_spectrum_accumulator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// corner register in micrometres
	function automatic longint corner_um(logic [21:0] r);
		longint v;
		v = $signed(r);
		return v * 1000;
	endfunction

	function automatic bit point_sel();
		return corner[rsa_pkg::CFG_A_X] == corner[rsa_pkg::CFG_B_X] &&
			corner[rsa_pkg::CFG_A_Y] == corner[rsa_pkg::CFG_B_Y];
	endfunction

	function automatic bit in_region(longint x, longint y);
		longint ax, ay, bx, by;
		ax = corner_um(corner[rsa_pkg::CFG_A_X]);
		ay = corner_um(corner[rsa_pkg::CFG_A_Y]);
		bx = corner_um(corner[rsa_pkg::CFG_B_X]);
		by = corner_um(corner[rsa_pkg::CFG_B_Y]);
		if (point_sel())
			return x == ax && y == ay;
		return x >= (ax < bx ? ax : bx) && x <= (ax < bx ? bx : ax) &&
			y >= (ay < by ? ay : by) && y <= (ay < by ? by : ay);
	endfunction

	// bin update: assignment in point mode, saturating add otherwise
	function automatic void bin_add(longint ch, longint cnt);
		longint b;
		if (ch < 0 || ch >= NUM_BINS)
			return;
		if (point_sel()) begin
			b = cnt < 0 ? 0 : (cnt > BIN_TOP ? BIN_TOP : cnt);
		end else begin
			b = spectrum[ch];
			b = b + cnt;
			if (b < 0)
				b = 0;
			else if (b > BIN_TOP)
				b = BIN_TOP;
		end
		spectrum[ch] = b[31:0];
	endfunction

	// one item through the predicted block
	function automatic rsa_pkg::rsa_out_t spectrum_step(rsa_pkg::rsa_in_t it);
		rsa_pkg::rsa_out_t r;
		logic signed [31:0] w;
		r = '0;
		w = it.stream_word;
		case (it.operation)
			rsa_pkg::OP_WORD: begin
				if (!stream_ended) begin
					case (rec_phase)
						AWAIT_X: begin
							if (w == rsa_pkg::WORD_STREAM_END) begin
								rec_phase = HALTED;
								stream_ended = 1'b1;
							end else begin
								rec_x = w;
								rec_phase = AWAIT_Y;
							end
						end
						AWAIT_Y: begin
							if (in_region(rec_x, w))
								rec_phase = AWAIT_INTEGRAL;
							else
								rec_phase = (w == rsa_pkg::WORD_REC_END) ? AWAIT_X : SKIP_REC;
						end
						AWAIT_INTEGRAL: rec_phase = AWAIT_COUNT;
						AWAIT_COUNT: begin
							if (w == rsa_pkg::WORD_STREAM_END) begin
								rec_phase = HALTED;
								stream_ended = 1'b1;
							end else if (w == rsa_pkg::WORD_REC_END) begin
								if (point_sel()) begin
									rec_phase = HALTED;
									stream_ended = 1'b1;
								end else begin
									rec_phase = AWAIT_X;
								end
							end else begin
								pend_count = w;
								rec_phase = AWAIT_CHANNEL;
							end
						end
						AWAIT_CHANNEL: begin
							bin_add(w, pend_count);
							rec_phase = AWAIT_COUNT;
						end
						SKIP_REC: begin
							if (w == rsa_pkg::WORD_STREAM_END) begin
								rec_phase = HALTED;
								stream_ended = 1'b1;
							end else if (w == rsa_pkg::WORD_REC_END) begin
								rec_phase = AWAIT_X;
							end
						end
						default: begin
							rec_phase = HALTED;
							stream_ended = 1'b1;
						end
					endcase
				end
			end
			rsa_pkg::OP_READ: r.bin_value = spectrum[it.read_channel];
			rsa_pkg::OP_CLEAR: begin
				foreach (spectrum[i])
					spectrum[i] = '0;
				rec_phase = AWAIT_X;
				rec_x = '0;
				pend_count = '0;
				stream_ended = 1'b0;
			end
			default: ;
		endcase
		r.stream_done = stream_ended;
		return r;
	endfunction

	function automatic void note_fault(string msg);
		if (fault_cnt < 10)
			$display("%s", msg);
		fault_cnt++;
	endfunction

	// result check first, then prediction of the item taken at this edge
	always @(posedge clk) begin
		rsa_pkg::rsa_out_t want;
		rsa_pkg::rsa_out_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_checked++;
				if (expected_results.size() == 0) begin
					note_fault($sformatf("result %0d arrived with nothing expected: bin %h done %b",
						results_checked, out_data.bin_value, out_data.stream_done));
				end else begin
					want = expected_results.pop_front();
					if (out_data.bin_value !== want.bin_value ||
						out_data.stream_done !== want.stream_done)
						note_fault($sformatf("result %0d: expected bin %h done %b, got bin %h done %b",
							results_checked, want.bin_value, want.stream_done,
							out_data.bin_value, out_data.stream_done));
				end
			end
			if (in_valid && in_ready) begin
				got = spectrum_step(in_data);
				expected_results.push_back(drv_typed ? drv_want : got);
				items_taken++;
				if (in_data.operation == rsa_pkg::OP_CLEAR)
					clears_taken++;
				if (in_data.operation == rsa_pkg::OP_READ)
					reads_taken++;
			end
		end
	end

	// receiver stalls
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	function automatic rsa_pkg::rsa_in_t mk_item(logic [1:0] op, logic [31:0] w,
		logic [13:0] ch);
		rsa_pkg::rsa_in_t it;
		it.operation = op;
		it.stream_word = w;
		it.read_channel = ch;
		return it;
	endfunction

	function automatic rsa_pkg::rsa_in_t stream_item(logic [31:0] w);
		return mk_item(rsa_pkg::OP_WORD, w, 14'($urandom()));
	endfunction

	function automatic row_t row_item(logic [1:0] op, logic [31:0] w, logic [13:0] ch);
		row_t r;
		r.kind = ROW_ITEM;
		r.item = mk_item(op, w, ch);
		r.typed = 1'b0;
		r.want = '0;
		r.reg_idx = '0;
		r.reg_val = '0;
		return r;
	endfunction

	function automatic row_t row_typed(logic [1:0] op, logic [31:0] w, logic [13:0] ch,
		logic [31:0] b, logic d);
		row_t r;
		r = row_item(op, w, ch);
		r.typed = 1'b1;
		r.want.bin_value = b;
		r.want.stream_done = d;
		return r;
	endfunction

	function automatic row_t row_reg(logic [1:0] idx, logic [21:0] val);
		row_t r;
		r = row_item(rsa_pkg::OP_WORD, '0, '0);
		r.kind = ROW_REG;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	// corner in whole millimetres within +-span
	function automatic logic [21:0] near_mm(int span);
		int v;
		v = $urandom_range(0, 2 * span);
		v = v - span;
		return v[21:0];
	endfunction

	// corner at either end of the register range or anywhere
	function automatic logic [21:0] wide_mm();
		case ($urandom_range(2))
			0: return 22'h20_0000;
			1: return 22'h1F_FFFF;
			default: return 22'($urandom());
		endcase
	endfunction

	// position word near or on the edges of a corner range in mm
	function automatic logic [31:0] pick_pos(longint lo, longint hi);
		longint v;
		case ($urandom_range(9))
			0: v = longint'(int'($urandom()));
			1: v = lo * 1000 - longint'($urandom_range(1, 999));
			2: v = hi * 1000 + longint'($urandom_range(1, 999));
			3: v = lo * 1000;
			4: v = hi * 1000;
			default: begin
				v = (lo - 1 + longint'($urandom_range(0, 32'(hi - lo + 2)))) * 1000;
				if ($urandom_range(2) == 0)
					v = v + longint'($urandom_range(0, 1998)) - 999;
			end
		endcase
		return v[31:0];
	endfunction

	function automatic logic [31:0] rand_count();
		case ($urandom_range(7))
			0: return 32'(-int'($urandom_range(1, 500)));
			1: return $urandom();
			2: return 32'h7FFF_FFFF;
			default: return $urandom_range(0, 500);
		endcase
	endfunction

	function automatic logic [31:0] rand_channel();
		case ($urandom_range(9))
			0: return $urandom();
			1: return rsa_pkg::WORD_REC_END;
			2, 3: return $urandom_range(0, NUM_BINS - 1);
			default: return $urandom_range(0, 15);
		endcase
	endfunction

	// one record with random content, sometimes with noise, truncated or ending the stream
	function automatic void plan_record(longint lox, longint hix, longint loy, longint hiy);
		int pairs;
		int ending;
		logic [1:0] nop;
		if ($urandom_range(9) == 0) begin
			nop = 2'($urandom_range(0, 2));
			if (nop == rsa_pkg::OP_CLEAR)
				nop = OP_UNUSED;
			plan.push_back(mk_item(nop, $urandom(), 14'($urandom())));
		end
		plan.push_back(stream_item(pick_pos(lox, hix)));
		plan.push_back(stream_item(pick_pos(loy, hiy)));
		plan.push_back(stream_item($urandom_range(7) == 0 ? rsa_pkg::WORD_REC_END : $urandom()));
		pairs = $urandom_range(0, 4);
		repeat (pairs) begin
			plan.push_back(stream_item(rand_count()));
			plan.push_back(stream_item(rand_channel()));
		end
		ending = $urandom_range(39);
		if (ending == 0)
			plan.push_back(stream_item(rsa_pkg::WORD_STREAM_END));
		else if (ending > 3)
			plan.push_back(stream_item(rsa_pkg::WORD_REC_END));
		if ($urandom_range(1))
			plan.push_back(mk_item(rsa_pkg::OP_READ, $urandom(),
				$urandom_range(3) == 0 ? 14'($urandom()) : 14'($urandom_range(0, 15))));
	endfunction

	// present one item, hold it until taken
	task automatic send_item(rsa_pkg::rsa_in_t it, bit typed, rsa_pkg::rsa_out_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		drv_typed = typed;
		drv_want = want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// drain everything in flight before touching registers
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (expected_results.size() != 0 || !in_ready)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [21:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		corner[idx] = val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [21:0] cs [4];
		longint ax, ay, bx, by;

		foreach (spectrum[i])
			spectrum[i] = '0;
		foreach (corner[i])
			corner[i] = '0;
		rec_phase = AWAIT_X;
		rec_x = '0;
		pend_count = '0;
		stream_ended = 1'b0;

		// point mode at the origin after reset
		rows.push_back(row_typed(rsa_pkg::OP_READ, '0, '0, '0, 1'b0));
		rows.push_back(row_typed(OP_UNUSED, rsa_pkg::WORD_STREAM_END, 14'h3FFF, '0, 1'b0));
		rows.push_back(row_item(rsa_pkg::OP_WORD, '0, '0));
		rows.push_back(row_item(rsa_pkg::OP_WORD, '0, 14'h3FFF));
		rows.push_back(row_item(rsa_pkg::OP_WORD, 32'd5, '0));
		rows.push_back(row_item(rsa_pkg::OP_WORD, -32'sd5, '0));
		rows.push_back(row_item(rsa_pkg::OP_WORD, 32'd7, '0));
		rows.push_back(row_item(rsa_pkg::OP_WORD, 32'h7FFF_FFFF, '0));
		rows.push_back(row_item(rsa_pkg::OP_WORD, 32'd16383, '0));
		rows.push_back(row_item(rsa_pkg::OP_WORD, 32'd9, '0));
		// end marker in the channel slot is just a bad channel
		rows.push_back(row_item(rsa_pkg::OP_WORD, rsa_pkg::WORD_REC_END, '0));
		rows.push_back(row_typed(rsa_pkg::OP_WORD, rsa_pkg::WORD_REC_END, '0, '0, 1'b1));
		rows.push_back(row_typed(rsa_pkg::OP_READ, '0, 14'h3FFF, 32'h7FFF_FFFF, 1'b1));
		rows.push_back(row_typed(rsa_pkg::OP_CLEAR, '0, '0, '0, 1'b0));
		// widest rectangle
		rows.push_back(row_reg(rsa_pkg::CFG_A_X, 22'h20_0000));
		rows.push_back(row_reg(rsa_pkg::CFG_A_Y, 22'h20_0000));
		rows.push_back(row_reg(rsa_pkg::CFG_B_X, 22'h1F_FFFF));
		rows.push_back(row_reg(rsa_pkg::CFG_B_Y, 22'h1F_FFFF));
		// skipped record ended by an end marker at the integral slot
		rows.push_back(row_item(rsa_pkg::OP_WORD, 32'h8000_0000, '0));
		rows.push_back(row_item(rsa_pkg::OP_WORD, '0, '0));
		rows.push_back(row_item(rsa_pkg::OP_WORD, rsa_pkg::WORD_REC_END, '0));
		// record on the corners, bin 3 saturates
		rows.push_back(row_item(rsa_pkg::OP_WORD, -32'sd2097152000, '0));
		rows.push_back(row_item(rsa_pkg::OP_WORD, 32'sd2097151000, '0));
		rows.push_back(row_item(rsa_pkg::OP_WORD, rsa_pkg::WORD_REC_END, '0));
		repeat (3) begin
			rows.push_back(row_item(rsa_pkg::OP_WORD, 32'h7FFF_FFFF, '0));
			rows.push_back(row_item(rsa_pkg::OP_WORD, 32'd3, '0));
		end
		rows.push_back(row_typed(rsa_pkg::OP_WORD, rsa_pkg::WORD_STREAM_END, '0, '0, 1'b1));
		rows.push_back(row_typed(rsa_pkg::OP_READ, '0, 14'd3, 32'hFFFF_FFFF, 1'b1));

		send_idle_pct = 29;
		recv_idle_pct = 81;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rows
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_REG) begin
				settle();
				write_reg(rows[i].reg_idx, rows[i].reg_val);
				settings_cnt++;
			end else begin
				send_item(rows[i].item, rows[i].typed, rows[i].want);
			end
		end

		// random episodes, each with its own corner setting
		for (int ep = 0; ep < EPISODES; ep++) begin
			if (ep < 5) begin
				send_idle_pct = 29;
				recv_idle_pct = 81;
			end else if (ep < 10) begin
				send_idle_pct = 81;
				recv_idle_pct = 29;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			settle();

			case (ep % 4)
				0: begin
					foreach (cs[i])
						cs[i] = near_mm(4);
					if (cs[rsa_pkg::CFG_A_X] == cs[rsa_pkg::CFG_B_X] &&
						cs[rsa_pkg::CFG_A_Y] == cs[rsa_pkg::CFG_B_Y])
						cs[rsa_pkg::CFG_B_X] = cs[rsa_pkg::CFG_A_X] + 22'd1;
				end
				1: begin
					foreach (cs[i])
						cs[i] = wide_mm();
				end
				2: begin
					cs[rsa_pkg::CFG_A_X] = near_mm(3);
					cs[rsa_pkg::CFG_A_Y] = near_mm(3);
					cs[rsa_pkg::CFG_B_X] = cs[rsa_pkg::CFG_A_X];
					cs[rsa_pkg::CFG_B_Y] = cs[rsa_pkg::CFG_A_Y];
				end
				default: begin
					// zero width in x, corners given high to low in y
					cs[rsa_pkg::CFG_A_X] = near_mm(3);
					cs[rsa_pkg::CFG_B_X] = cs[rsa_pkg::CFG_A_X];
					cs[rsa_pkg::CFG_A_Y] = near_mm(2);
					cs[rsa_pkg::CFG_B_Y] = cs[rsa_pkg::CFG_A_Y] - 22'($urandom_range(1, 4));
				end
			endcase
			write_reg(rsa_pkg::CFG_A_X, cs[rsa_pkg::CFG_A_X]);
			write_reg(rsa_pkg::CFG_A_Y, cs[rsa_pkg::CFG_A_Y]);
			write_reg(rsa_pkg::CFG_B_X, cs[rsa_pkg::CFG_B_X]);
			write_reg(rsa_pkg::CFG_B_Y, cs[rsa_pkg::CFG_B_Y]);
			settings_cnt++;

			// restart when the stream has ended, sometimes mid-record too
			if (stream_ended || $urandom_range(3) == 0)
				send_item(mk_item(rsa_pkg::OP_CLEAR, $urandom(), 14'($urandom())), 1'b0, '0);

			ax = $signed(cs[rsa_pkg::CFG_A_X]);
			ay = $signed(cs[rsa_pkg::CFG_A_Y]);
			bx = $signed(cs[rsa_pkg::CFG_B_X]);
			by = $signed(cs[rsa_pkg::CFG_B_Y]);
			plan.delete();
			while (plan.size() < EPISODE_ITEMS)
				plan_record(ax < bx ? ax : bx, ax < bx ? bx : ax,
					ay < by ? ay : by, ay < by ? by : ay);
			foreach (plan[i])
				send_item(plan[i], 1'b0, '0);
		end

		settle();
		$display("covered %0d items (%0d reads, %0d clears) over %0d corner settings",
			items_taken, reads_taken, clears_taken, settings_cnt);
		$display("%0d results checked, %0d mismatches", results_checked, fault_cnt);
		if (fault_cnt == 0 && expected_results.size() == 0)
			$display("tb_region_spectrum_accumulator: PASS");
		else
			$display("tb_region_spectrum_accumulator: FAIL");
		$finish;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("tb_region_spectrum_accumulator: FAIL");
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/rsa_pkg.sv
src/rsa_ram.sv
src/rsa_parser.sv
src/region_spectrum_accumulator.sv
src/rsa_checker.sv
sim/tb_region_spectrum_accumulator.sv
